FILE: hw/rtl/bdt_pkg.sv
// Package for the Baudot TTY decoder: shared types, constants and code tables.
package bdt_pkg;

   localparam int unsigned FRAME_W = 8;
   localparam int unsigned CODE_W  = 5;
   localparam int unsigned CHAR_W  = 8;

   localparam logic [CHAR_W-1:0] SHIFT_OUT_CHAR = 8'h0E;
   localparam logic [CHAR_W-1:0] SHIFT_IN_CHAR  = 8'h0F;
   localparam logic [CHAR_W-1:0] ENQ_CHAR       = 8'h05;
   localparam logic [CHAR_W-1:0] POUND_CHAR     = 8'h9C;

   typedef enum logic {
      MODE_LETTERS = 1'b0,
      MODE_FIGURES = 1'b1
   } mode_type;

   typedef enum logic {
      FIGS_US = 1'b0,
      FIGS_EU = 1'b1
   } figs_std_type;

   // Result of decoding one frame.
   typedef struct packed {
      logic              is_shift;
      logic [CHAR_W-1:0] char_code;
   } decode_type;

   function automatic logic [CHAR_W-1:0] ltrs_lookup(input logic [CODE_W-1:0] code);
      logic [CHAR_W-1:0] ch;
      case (code)
         5'd0:  ch = 8'h08;
         5'd1:  ch = "E";
         5'd2:  ch = 8'h0A;
         5'd3:  ch = "A";
         5'd4:  ch = " ";
         5'd5:  ch = "S";
         5'd6:  ch = "I";
         5'd7:  ch = "U";
         5'd8:  ch = 8'h0D;
         5'd9:  ch = "D";
         5'd10: ch = "R";
         5'd11: ch = "J";
         5'd12: ch = "N";
         5'd13: ch = "F";
         5'd14: ch = "C";
         5'd15: ch = "K";
         5'd16: ch = "T";
         5'd17: ch = "Z";
         5'd18: ch = "L";
         5'd19: ch = "W";
         5'd20: ch = "H";
         5'd21: ch = "Y";
         5'd22: ch = "P";
         5'd23: ch = "Q";
         5'd24: ch = "O";
         5'd25: ch = "B";
         5'd26: ch = "G";
         5'd27: ch = SHIFT_OUT_CHAR;
         5'd28: ch = "M";
         5'd29: ch = "X";
         5'd30: ch = "V";
         default: ch = SHIFT_IN_CHAR;
      endcase
      return ch;
   endfunction

   function automatic logic [CHAR_W-1:0] figs_us_lookup(input logic [CODE_W-1:0] code);
      logic [CHAR_W-1:0] ch;
      case (code)
         5'd0:  ch = 8'h08;
         5'd1:  ch = "3";
         5'd2:  ch = 8'h0A;
         5'd3:  ch = "-";
         5'd4:  ch = " ";
         5'd5:  ch = 8'h07;
         5'd6:  ch = "8";
         5'd7:  ch = "7";
         5'd8:  ch = 8'h0D;
         5'd9:  ch = "$";
         5'd10: ch = "4";
         5'd11: ch = 8'h27;
         5'd12: ch = ",";
         5'd13: ch = "!";
         5'd14: ch = ":";
         5'd15: ch = "(";
         5'd16: ch = "5";
         5'd17: ch = 8'h22;
         5'd18: ch = ")";
         5'd19: ch = "2";
         5'd20: ch = "=";
         5'd21: ch = "6";
         5'd22: ch = "0";
         5'd23: ch = "1";
         5'd24: ch = "9";
         5'd25: ch = "?";
         5'd26: ch = "+";
         5'd27: ch = SHIFT_OUT_CHAR;
         5'd28: ch = ".";
         5'd29: ch = "/";
         5'd30: ch = ";";
         default: ch = SHIFT_IN_CHAR;
      endcase
      return ch;
   endfunction

   function automatic logic [CHAR_W-1:0] figs_eu_lookup(input logic [CODE_W-1:0] code);
      logic [CHAR_W-1:0] ch;
      case (code)
         5'd0:  ch = 8'h08;
         5'd1:  ch = "3";
         5'd2:  ch = 8'h0A;
         5'd3:  ch = "-";
         5'd4:  ch = " ";
         5'd5:  ch = 8'h27;
         5'd6:  ch = "8";
         5'd7:  ch = "7";
         5'd8:  ch = 8'h0D;
         5'd9:  ch = ENQ_CHAR;
         5'd10: ch = "4";
         5'd11: ch = 8'h07;
         5'd12: ch = ",";
         5'd13: ch = "!";
         5'd14: ch = ":";
         5'd15: ch = "(";
         5'd16: ch = "5";
         5'd17: ch = "+";
         5'd18: ch = ")";
         5'd19: ch = "2";
         5'd20: ch = POUND_CHAR;
         5'd21: ch = "6";
         5'd22: ch = "0";
         5'd23: ch = "1";
         5'd24: ch = "9";
         5'd25: ch = "?";
         5'd26: ch = "&";
         5'd27: ch = SHIFT_OUT_CHAR;
         5'd28: ch = ".";
         5'd29: ch = "/";
         5'd30: ch = "=";
         default: ch = SHIFT_IN_CHAR;
      endcase
      return ch;
   endfunction

endpackage

FILE: hw/rtl/baudot_tty_decoder.sv
// Top level of the Baudot TTY decoder.
// Each request transaction carries one received frame byte whose bits 5..1 hold a Baudot
// code; bits 0, 6 and 7 are ignored. The block keeps a letters/figures mode, starting in
// letters after reset, and looks the code up in the letters table or in the US or European
// figures table chosen by csr_wr_data (0 US, 1 European). The user must write it only while
// the block is idle; the block itself does not enforce this. The two shift codes change the
// mode and produce no response; every other code produces one response transaction with the
// character byte. A non-shift frame passes through the input register and then the result
// register, which holds it until the sink takes it; one frame is taken per cycle as long as
// the sink keeps rsp_tready high; while both registers are full and the held frame is not a
// shift code, req_tready follows rsp_tready.
module baudot_tty_decoder import bdt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic               csr_wr_data,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [FRAME_W-1:0] req_tdata,   // [7:0] frame_byte
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [CHAR_W-1:0]  rsp_tdata    // [7:0] decoded_char
);

   logic               hold_valid;
   logic [FRAME_W-1:0] hold_byte;
   logic               advance;
   logic               free;
   decode_type         result;

   // A shift frame never needs the result register, so it may leave at any time.
   assign advance = hold_valid && (result.is_shift || free);

   bdt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .hold_valid (hold_valid),
      .hold_byte  (hold_byte)
   );

   bdt_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .frame_byte  (hold_byte),
      .advance     (advance),
      .result      (result)
   );

   bdt_result u_result (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && !result.is_shift),
      .load_char  (result.char_code),
      .free       (free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: hw/rtl/bdt_front.sv
// Input register stage: holds one received frame byte until the decoder takes it.
module bdt_front import bdt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [FRAME_W-1:0] req_tdata,
   input  logic               advance,
   output logic               hold_valid,
   output logic [FRAME_W-1:0] hold_byte
);

   logic               valid_ff, valid_in;
   logic [FRAME_W-1:0] byte_ff, byte_in;
   logic               accept;

   assign req_tready = !valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (accept) begin
         valid_in = 1'b1;
         byte_in  = req_tdata;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign hold_valid = valid_ff;
   assign hold_byte  = byte_ff;

endmodule

FILE: hw/rtl/bdt_decode.sv
// Decoder: shift mode, figures table choice and the table lookup of one frame.
module bdt_decode import bdt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic               csr_wr_data,
   input  logic [FRAME_W-1:0] frame_byte,
   input  logic               advance,
   output decode_type         result
);

   mode_type          mode_ff, mode_in;
   figs_std_type      figs_ff, figs_in;
   logic [CODE_W-1:0] code;
   logic [CHAR_W-1:0] ch;

   assign code = frame_byte[CODE_W:1];

   always_comb begin
      if (mode_ff == MODE_LETTERS) begin
         ch = ltrs_lookup(code);
      end else if (figs_ff == FIGS_EU) begin
         ch = figs_eu_lookup(code);
      end else begin
         ch = figs_us_lookup(code);
      end
   end

   assign result.char_code = ch;
   assign result.is_shift  = (ch == SHIFT_IN_CHAR) || (ch == SHIFT_OUT_CHAR);

   // The mode only changes when the frame actually leaves the input register.
   always_comb begin
      mode_in = mode_ff;
      if (advance && ch == SHIFT_IN_CHAR) begin
         mode_in = MODE_LETTERS;
      end else if (advance && ch == SHIFT_OUT_CHAR) begin
         mode_in = MODE_FIGURES;
      end
   end

   assign figs_in = csr_wr_en ? figs_std_type'(csr_wr_data) : figs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_LETTERS;
         figs_ff <= FIGS_US;
      end else begin
         mode_ff <= mode_in;
         figs_ff <= figs_in;
      end
   end

endmodule

FILE: hw/rtl/bdt_result.sv
// Result register: holds one decoded character until the sink takes it.
module bdt_result import bdt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic [CHAR_W-1:0] load_char,
   output logic              free,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [CHAR_W-1:0] rsp_tdata
);

   logic              valid_ff, valid_in;
   logic [CHAR_W-1:0] data_ff, data_in;

   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_char;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

FILE: hw/rtl/bdt_checker.sv
// Port-level checker for the Baudot TTY decoder, bound to the top level.
module bdt_checker import bdt_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_tvalid,
   input logic               req_tready,
   input logic               rsp_tvalid,
   input logic               rsp_tready,
   input logic [CHAR_W-1:0]  rsp_tdata
);

   logic req_acc;

   assign req_acc = req_tvalid && req_tready;

   // A shift code is consumed inside the block and never shows up as a response.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata != SHIFT_IN_CHAR) && (rsp_tdata != SHIFT_OUT_CHAR))
      else $error("shift code delivered as a response");

   // A fresh response is always a request that went through both registers.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_acc, 2))
      else $error("response appeared without a matching request");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid straight after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed or vanished");

endmodule

bind baudot_tty_decoder bdt_checker u_bdt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
